@@ sv/sorted_key_table_unit_macros.svh @@
// ----------------------------------------------------------------------------
// sorted_key_table_unit_macros.svh
// Assertion macros shared by the sorted key table RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_UNIT_MACROS_SVH
`define SORTED_KEY_TABLE_UNIT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SKT_ASSERT_ALWAYS(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Types and constants of the sorted key table unit.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int KEY_W      = 24;
	localparam int SCORE_IN_W = 15;
	localparam int SCORE_W    = 14;
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 6;
	localparam int REQ_W      = 2;

	// 100.00 in hundredths
	localparam int SCORE_MAX  = 10000;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT   = 2'd0,
		REQ_DELETE   = 2'd1,
		REQ_DUMP     = 2'd2,
		REQ_RESERVED = 2'd3
	} req_type_t;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_INSERT,
		OP_BAD_SCORE,
		OP_DELETE,
		OP_DUMP
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED   = 3'd0,
		ST_DUPLICATE  = 3'd1,
		ST_RANGE      = 3'd2,
		ST_FULL       = 3'd3,
		ST_DELETED    = 3'd4,
		ST_NOTFOUND   = 3'd5,
		ST_DUMP_ENTRY = 3'd6
	} status_t;

	typedef struct packed {
		op_t                op;
		logic [KEY_W-1:0]   key;
		logic [SCORE_W-1:0] score;
	} item_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EXEC,
		B_DUMP
	} back_state_t;

endpackage

@@ sv/sorted_key_table_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_unit
// Bounded key/score table kept in ascending key order: insert, delete, dump.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_type, key, score
// rsp     | out       | rsp_valid/rsp_stall  | status, entry_count, entry_key,
//         |           |                      | entry_score, last
//
// Insert and delete work from the queue head: compare all cells, then shift.
// A dump sends one entry per cycle through the head cell unless the output stalls; an empty table gives one item.
// A two-item queue lets requests arrive while the table works.
// Reset clears the fill level and control; cell contents are not reset.
// rsp_stall holds the output register and the table waits; req_stall rises on a full queue.
// ----------------------------------------------------------------------------
module sorted_key_table_unit #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic [skt_pkg::REQ_W-1:0]             req_type,
	input  logic [skt_pkg::KEY_W-1:0]             key,
	input  logic signed [skt_pkg::SCORE_IN_W-1:0] score,
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output logic [skt_pkg::STATUS_W-1:0]          status,
	output logic [skt_pkg::COUNT_W-1:0]           entry_count,
	output logic [skt_pkg::KEY_W-1:0]             entry_key,
	output logic [skt_pkg::SCORE_W-1:0]           entry_score,
	output logic                                  last
);

	logic           q_push, q_full, q_pop, q_empty;
	skt_pkg::item_t push_item, head_item;

	skt_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.key       (key),
		.score     (score),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	skt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (head_item),
		.empty     (q_empty)
	);

	skt_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (head_item),
		.q_pop       (q_pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.entry_count (entry_count),
		.entry_key   (entry_key),
		.entry_score (entry_score),
		.last        (last)
	);

endmodule

@@ sv/skt_queue.sv @@
// ----------------------------------------------------------------------------
// skt_queue
// Small FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`include "sorted_key_table_unit_macros.svh"

module skt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  skt_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output skt_pkg::item_t pop_item,
	output logic           empty
);

	localparam int DEPTH = skt_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	skt_pkg::item_t entries_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	`SKT_ASSERT_ALWAYS(a_queue_no_overflow, !(push && full), "push into full queue")
	`SKT_ASSERT_ALWAYS(a_queue_no_underflow, !(pop && empty), "pop from empty queue")

endmodule

@@ sv/skt_front.sv @@
// ----------------------------------------------------------------------------
// skt_front
// Accepts request items, checks the score range and drops unused codes.
// ----------------------------------------------------------------------------
module skt_front (
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [skt_pkg::REQ_W-1:0]            req_type,
	input  logic [skt_pkg::KEY_W-1:0]            key,
	input  logic signed [skt_pkg::SCORE_IN_W-1:0] score,
	input  logic                                 q_full,
	output logic                                 q_push,
	output skt_pkg::item_t                       q_item
);

	localparam int SW = skt_pkg::SCORE_W;

	skt_pkg::req_type_t req;
	logic               score_ok;

	assign req       = skt_pkg::req_type_t'(req_type);
	assign score_ok  = !score[skt_pkg::SCORE_IN_W-1] &&
		(score[SW-1:0] <= SW'(skt_pkg::SCORE_MAX));
	assign req_stall = q_full;

	always_comb begin
		q_push       = req_valid && !q_full;
		q_item.key   = key;
		q_item.score = score[SW-1:0];
		q_item.op    = skt_pkg::OP_INSERT;
		case (req)
			skt_pkg::REQ_INSERT: q_item.op = score_ok ? skt_pkg::OP_INSERT : skt_pkg::OP_BAD_SCORE;
			skt_pkg::REQ_DELETE: q_item.op = skt_pkg::OP_DELETE;
			skt_pkg::REQ_DUMP:   q_item.op = skt_pkg::OP_DUMP;
			default:             q_push    = 1'b0;  // unused code: taken, no result
		endcase
	end

endmodule

@@ sv/skt_back.sv @@
// ----------------------------------------------------------------------------
// skt_back
// Sorted table of cells with compare, insert/delete shift and dump rotation.
// ----------------------------------------------------------------------------
`include "sorted_key_table_unit_macros.svh"

module skt_back #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  skt_pkg::item_t               q_item,
	output logic                         q_pop,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [skt_pkg::STATUS_W-1:0] status,
	output logic [skt_pkg::COUNT_W-1:0]  entry_count,
	output logic [skt_pkg::KEY_W-1:0]    entry_key,
	output logic [skt_pkg::SCORE_W-1:0]  entry_score,
	output logic                         last
);

	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int KW  = skt_pkg::KEY_W;
	localparam int SW  = skt_pkg::SCORE_W;
	localparam int OCW = skt_pkg::COUNT_W;

	skt_pkg::back_state_t state_q, state_d;
	skt_pkg::item_t       item_q;

	logic [KW-1:0] key_q   [TABLE_DEPTH];
	logic [SW-1:0] score_q [TABLE_DEPTH];
	logic [CW-1:0] fill_q, fill_d;
	logic [CW-1:0] dump_idx_q, dump_idx_d;

	logic [TABLE_DEPTH-1:0] lt_c, ge_c, eq_c;
	logic [TABLE_DEPTH-1:0] lt_q, ge_q;
	logic                   hit_q;

	logic [KW-1:0] ins_key [TABLE_DEPTH];
	logic [SW-1:0] ins_scr [TABLE_DEPTH];
	logic [KW-1:0] nxt_key [TABLE_DEPTH];
	logic [SW-1:0] nxt_scr [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] take_next, take_head;

	logic             out_free, load_out, cmp_en;
	logic             do_ins, do_del, do_rot;
	skt_pkg::status_t st_d, st_q;
	logic [KW-1:0]    ekey_d, ekey_q;
	logic [SW-1:0]    escore_d, escore_q;
	logic             last_d, last_q;
	logic [OCW-1:0]   count_q;
	logic             rsp_valid_q;
	logic             ins_done, last_done;

	// per-cell compare and neighbor selects
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		logic cell_vld;
		assign cell_vld     = (CW'(g) < fill_q);
		assign lt_c[g]      = cell_vld && (key_q[g] <  q_item.key);
		assign ge_c[g]      = cell_vld && (key_q[g] >= q_item.key);
		assign eq_c[g]      = cell_vld && (key_q[g] == q_item.key);
		assign take_next[g] = (CW'(g + 1) <  fill_q);
		assign take_head[g] = (CW'(g + 1) == fill_q);
		if (g == 0) begin : g_first
			assign ins_key[g] = item_q.key;
			assign ins_scr[g] = item_q.score;
		end else begin : g_rest
			assign ins_key[g] = lt_q[g-1] ? item_q.key   : key_q[g-1];
			assign ins_scr[g] = lt_q[g-1] ? item_q.score : score_q[g-1];
		end
		if (g < TABLE_DEPTH - 1) begin : g_mid
			assign nxt_key[g] = key_q[g+1];
			assign nxt_scr[g] = score_q[g+1];
		end else begin : g_end
			assign nxt_key[g] = key_q[g];
			assign nxt_scr[g] = score_q[g];
		end
	end

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		cmp_en     = 1'b0;
		load_out   = 1'b0;
		do_ins     = 1'b0;
		do_del     = 1'b0;
		do_rot     = 1'b0;
		fill_d     = fill_q;
		dump_idx_d = dump_idx_q;
		st_d       = skt_pkg::ST_INSERTED;
		ekey_d     = '0;
		escore_d   = '0;
		last_d     = 1'b1;
		case (state_q)
			skt_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop      = 1'b1;
					cmp_en     = 1'b1;
					dump_idx_d = '0;
					state_d    = (q_item.op == skt_pkg::OP_DUMP) ? skt_pkg::B_DUMP
						: skt_pkg::B_EXEC;
				end
			end
			skt_pkg::B_EXEC: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = skt_pkg::B_IDLE;
					case (item_q.op)
						skt_pkg::OP_BAD_SCORE: st_d = skt_pkg::ST_RANGE;
						skt_pkg::OP_INSERT: begin
							if (hit_q) begin
								st_d = skt_pkg::ST_DUPLICATE;
							end else if (fill_q == CW'(TABLE_DEPTH)) begin
								st_d = skt_pkg::ST_FULL;
							end else begin
								st_d   = skt_pkg::ST_INSERTED;
								do_ins = 1'b1;
								fill_d = fill_q + CW'(1);
							end
						end
						skt_pkg::OP_DELETE: begin
							if (hit_q) begin
								st_d   = skt_pkg::ST_DELETED;
								do_del = 1'b1;
								fill_d = fill_q - CW'(1);
							end else begin
								st_d = skt_pkg::ST_NOTFOUND;
							end
						end
						default: load_out = 1'b0;
					endcase
				end
			end
			skt_pkg::B_DUMP: begin
				if (out_free) begin
					load_out = 1'b1;
					st_d     = skt_pkg::ST_DUMP_ENTRY;
					if (fill_q == '0) begin
						state_d = skt_pkg::B_IDLE;
					end else begin
						// emit head cell, rotate the filled part left by one
						ekey_d     = key_q[0];
						escore_d   = score_q[0];
						do_rot     = 1'b1;
						last_d     = (dump_idx_q + CW'(1) == fill_q);
						dump_idx_d = dump_idx_q + CW'(1);
						if (last_d) begin
							state_d = skt_pkg::B_IDLE;
						end
					end
				end
			end
			default: state_d = skt_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skt_pkg::B_IDLE;
			fill_q      <= '0;
			dump_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			fill_q     <= fill_d;
			dump_idx_q <= dump_idx_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			item_q <= q_item;
			lt_q   <= lt_c;
			ge_q   <= ge_c;
			hit_q  <= |eq_c;
		end
		if (load_out) begin
			st_q     <= st_d;
			count_q  <= OCW'(fill_d);
			ekey_q   <= ekey_d;
			escore_q <= escore_d;
			last_q   <= last_d;
		end
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (do_ins && !lt_q[i]) begin
				key_q[i]   <= ins_key[i];
				score_q[i] <= ins_scr[i];
			end else if ((do_del && ge_q[i]) || (do_rot && take_next[i])) begin
				key_q[i]   <= nxt_key[i];
				score_q[i] <= nxt_scr[i];
			end else if (do_rot && take_head[i]) begin
				key_q[i]   <= key_q[0];
				score_q[i] <= score_q[0];
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = st_q;
	assign entry_count = count_q;
	assign entry_key   = ekey_q;
	assign entry_score = escore_q;
	assign last        = last_q;

	assign ins_done  = load_out && (st_d == skt_pkg::ST_INSERTED);
	assign last_done = load_out && last_d;

	`SKT_ASSERT_ALWAYS(a_fill_bound, fill_q <= CW'(TABLE_DEPTH), "fill level above depth")
	`SKT_ASSERT_NEXT(a_ins_grows, ins_done, fill_q == $past(fill_q) + CW'(1), "fill did not grow")
	`SKT_ASSERT_NEXT(a_last_to_idle, last_done, state_q == skt_pkg::B_IDLE, "busy after last item")

endmodule

@@ tb/sorted_key_table_unit_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_unit_tb
// Self-checking bench for the sorted key table. A scoreboard class keeps its
// own sorted copy of the table. It predicts the status, count and dump
// entries of every accepted request, and it checks each response item in
// order. Stimulus is a directed opening followed by random phases that fill
// the table to capacity and drain it again. Both sides idle at random, and
// the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module sorted_key_table_unit_tb;

	localparam int DEPTH      = 32;
	localparam int ITEMS      = 200;
	localparam int HOLD_OFF   = 300;
	localparam int DRAIN_WAIT = 80;
	localparam int LIMIT      = 300000;

	localparam int KEY_W      = skt_pkg::KEY_W;
	localparam int SCORE_IN_W = skt_pkg::SCORE_IN_W;
	localparam int SCORE_W    = skt_pkg::SCORE_W;
	localparam int STATUS_W   = skt_pkg::STATUS_W;
	localparam int COUNT_W    = skt_pkg::COUNT_W;
	localparam int REQ_W      = skt_pkg::REQ_W;
	localparam int SCORE_MAX  = skt_pkg::SCORE_MAX;

	typedef struct packed {
		skt_pkg::status_t     status;
		logic [COUNT_W-1:0]   count;
		logic [KEY_W-1:0]     key;
		logic [SCORE_W-1:0]   score;
		logic                 last;
	} table_result_t;

	class key_table_checker;
		logic [KEY_W-1:0]   keys   [DEPTH];
		logic [SCORE_W-1:0] scores [DEPTH];
		int                 fill;
		table_result_t      pending [$];
		int                 errors, checked, accepted;
		int                 n_insert, n_delete, n_dump, n_full, peak;

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function void queue_result(skt_pkg::status_t st, logic [KEY_W-1:0] k,
				logic [SCORE_W-1:0] s, logic l);
			table_result_t r;
			r.status = st;
			r.count  = COUNT_W'(fill);
			r.key    = k;
			r.score  = s;
			r.last   = l;
			pending.push_back(r);
		endfunction

		function void apply_request(skt_pkg::req_type_t req, logic [KEY_W-1:0] k,
				logic signed [SCORE_IN_W-1:0] sc);
			int               pos;
			int               s;
			skt_pkg::status_t st;
			s = sc;
			accepted++;
			case (req)
			skt_pkg::REQ_INSERT: begin
				n_insert++;
				pos = 0;
				while (pos < fill && keys[pos] < k)
					pos++;
				// range check wins over duplicate, duplicate over full
				if (s < 0 || s > SCORE_MAX)
					st = skt_pkg::ST_RANGE;
				else if (pos < fill && keys[pos] == k)
					st = skt_pkg::ST_DUPLICATE;
				else if (fill >= DEPTH)
					st = skt_pkg::ST_FULL;
				else begin
					for (int i = fill; i > pos; i--) begin
						keys[i]   = keys[i-1];
						scores[i] = scores[i-1];
					end
					keys[pos]   = k;
					scores[pos] = SCORE_W'(s);
					fill++;
					st = skt_pkg::ST_INSERTED;
				end
				if (st == skt_pkg::ST_FULL)
					n_full++;
				if (fill > peak)
					peak = fill;
				queue_result(st, '0, '0, 1'b1);
			end
			skt_pkg::REQ_DELETE: begin
				n_delete++;
				pos = 0;
				while (pos < fill && keys[pos] != k)
					pos++;
				if (pos >= fill)
					st = skt_pkg::ST_NOTFOUND;
				else begin
					for (int i = pos; i + 1 < fill; i++) begin
						keys[i]   = keys[i+1];
						scores[i] = scores[i+1];
					end
					fill--;
					st = skt_pkg::ST_DELETED;
				end
				queue_result(st, '0, '0, 1'b1);
			end
			skt_pkg::REQ_DUMP: begin
				n_dump++;
				if (fill == 0)
					queue_result(skt_pkg::ST_DUMP_ENTRY, '0, '0, 1'b1);
				else
					for (int i = 0; i < fill; i++)
						queue_result(skt_pkg::ST_DUMP_ENTRY, keys[i], scores[i],
							i == fill - 1);
			end
			default: ;	// reserved request: no item out, no change
			endcase
		endfunction

		task check_result(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt,
				logic [KEY_W-1:0] k, logic [SCORE_W-1:0] s, logic l);
			table_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected item: status %0d count %0d key %0h", st, cnt, k));
				return;
			end
			want = pending.pop_front();
			checked++;
			if (st !== want.status)
				report($sformatf("item %0d status %0d, want %0d", checked, st, want.status));
			if (cnt !== want.count)
				report($sformatf("item %0d count %0d, want %0d", checked, cnt, want.count));
			if (k !== want.key)
				report($sformatf("item %0d key %0h, want %0h", checked, k, want.key));
			if (s !== want.score)
				report($sformatf("item %0d score %0d, want %0d", checked, s, want.score));
			if (l !== want.last)
				report($sformatf("item %0d last %0b, want %0b", checked, l, want.last));
		endtask
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         req_valid;
	logic                         req_stall;
	logic [REQ_W-1:0]             req_type;
	logic [KEY_W-1:0]             key;
	logic signed [SCORE_IN_W-1:0] score;
	logic                         rsp_valid;
	logic                         rsp_stall;
	logic [STATUS_W-1:0]          status;
	logic [COUNT_W-1:0]           entry_count;
	logic [KEY_W-1:0]             entry_key;
	logic [SCORE_W-1:0]           entry_score;
	logic                         last;

	key_table_checker sb;
	bit               no_idle  = 1'b0;
	bit               held_off = 1'b0;
	int               cycles;

	always #4 clk = ~clk;

	sorted_key_table_unit #(
		.TABLE_DEPTH (DEPTH)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.key         (key),
		.score       (score),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.entry_count (entry_count),
		.entry_key   (entry_key),
		.entry_score (entry_score),
		.last        (last)
	);

	task automatic send_req(skt_pkg::req_type_t t, logic [KEY_W-1:0] k,
			logic [SCORE_IN_W-1:0] sc);
		if (!no_idle && $urandom_range(99) < 20) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= t;
		key       <= k;
		score     <= sc;
		do @(posedge clk); while (req_stall);
		sb.apply_request(t, k, sc);
	endtask

	// grow phases are insert heavy so the table reaches capacity
	task automatic send_random(bit grow, output bit counted);
		int                    pick;
		logic [KEY_W-1:0]      k;
		logic [SCORE_IN_W-1:0] sc;
		skt_pkg::req_type_t    t;
		pick = $urandom_range(99);
		k    = KEY_W'($urandom);
		sc   = SCORE_IN_W'($urandom);
		if (pick < 3)
			t = skt_pkg::REQ_RESERVED;
		else if (pick < 11)
			t = skt_pkg::REQ_DUMP;
		else if ($urandom_range(99) < (grow ? 90 : 25)) begin
			t    = skt_pkg::REQ_INSERT;
			pick = $urandom_range(99);
			if (pick < 15 && sb.fill > 0)
				k = sb.keys[$urandom_range(sb.fill - 1)];
			else if (pick < 55)
				k = KEY_W'($urandom_range(255));
			if ($urandom_range(99) >= 12)
				sc = SCORE_IN_W'($urandom_range(SCORE_MAX));
		end else begin
			t = skt_pkg::REQ_DELETE;
			if ($urandom_range(99) < 75 && sb.fill > 0)
				k = sb.keys[$urandom_range(sb.fill - 1)];
			else if ($urandom_range(1))
				k = KEY_W'($urandom_range(255));
		end
		counted = (t != skt_pkg::REQ_RESERVED);
		send_req(t, k, sc);
	endtask

	initial begin
		int n;
		bit counted;
		sb = new();
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_type  <= skt_pkg::REQ_INSERT;
		key       <= '0;
		score     <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, extremes of key and score, check order, reserved type
		send_req(skt_pkg::REQ_DUMP,     24'h000000, 15'd0);
		send_req(skt_pkg::REQ_DELETE,   24'h000005, 15'd0);
		send_req(skt_pkg::REQ_RESERVED, 24'hFFFFFF, 15'h7FFF);
		send_req(skt_pkg::REQ_INSERT,   24'h000000, 15'd0);
		send_req(skt_pkg::REQ_INSERT,   24'hFFFFFF, SCORE_IN_W'(SCORE_MAX));
		send_req(skt_pkg::REQ_INSERT,   24'h800000, SCORE_IN_W'(SCORE_MAX + 1));
		send_req(skt_pkg::REQ_INSERT,   24'h000123, 15'h7FFF);	// -1
		send_req(skt_pkg::REQ_INSERT,   24'h000007, 15'h4000);	// most negative
		send_req(skt_pkg::REQ_INSERT,   24'h000009, 15'h3FFF);	// most positive
		send_req(skt_pkg::REQ_INSERT,   24'h000000, 15'd5);		// duplicate
		send_req(skt_pkg::REQ_INSERT,   24'h000000, 15'h7FFD);	// duplicate with bad score
		send_req(skt_pkg::REQ_INSERT,   24'h555555, 15'h1555);
		send_req(skt_pkg::REQ_INSERT,   24'hAAAAAA, 15'h0AAA);
		send_req(skt_pkg::REQ_DUMP,     24'h123456, 15'h2222);
		send_req(skt_pkg::REQ_DELETE,   24'h555554, 15'd0);
		send_req(skt_pkg::REQ_DELETE,   24'h000000, 15'h7FFF);
		send_req(skt_pkg::REQ_DELETE,   24'hFFFFFF, 15'd0);
		send_req(skt_pkg::REQ_RESERVED, 24'h5A5A5A, 15'h2AAA);
		send_req(skt_pkg::REQ_DUMP,     24'hFFFFFF, 15'h7FFF);
		send_req(skt_pkg::REQ_DELETE,   24'hAAAAAA, 15'd0);
		send_req(skt_pkg::REQ_DELETE,   24'h555555, 15'd0);
		send_req(skt_pkg::REQ_DELETE,   24'h555555, 15'd0);
		send_req(skt_pkg::REQ_DUMP,     24'h000000, 15'd0);

		n = 0;
		while (n < ITEMS) begin
			no_idle = (n >= 120 && n < 170);
			send_random((n % 100) < 60, counted);
			if (counted)
				n++;
		end
		no_idle = 1'b0;
		req_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d inserts, %0d deletes, %0d dumps; %0d items checked, %0d mismatches.",
			sb.n_insert, sb.n_delete, sb.n_dump, sb.checked, sb.errors);
		$display("Table peaked at %0d of %0d entries; %0d inserts refused on a full table.",
			sb.peak, DEPTH, sb.n_full);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// response side: check accepted items, random stall, one long hold-off
	initial begin
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				sb.check_result(status, entry_count, entry_key, entry_score, last);
			if (!held_off && sb.accepted >= 70) begin
				held_off = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				rsp_stall <= !no_idle && ($urandom_range(99) < 20);
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d items outstanding", cycles, sb.pending.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/skt_pkg.sv
sv/skt_queue.sv
sv/skt_front.sv
sv/skt_back.sv
sv/sorted_key_table_unit.sv
tb/sorted_key_table_unit_tb.sv
